// ----- rtl/bba_pkg.sv -----
// Shared types and constants for the block bitmap allocator.
// Used by the controller, the datapath, the top level and the checker; no dependencies.
package bba_pkg;

    localparam int MAP_BYTES = 1024;
    localparam int FUNC_W    = 2;
    localparam int BLK_W     = 13;
    localparam int BYTE_W    = 8;
    localparam int ACTIVE_W  = 11;
    localparam int BIT_W     = $clog2(BYTE_W);
    localparam int IDX_W     = $clog2(MAP_BYTES);
    // summary: one bit per bitmap byte, packed into words, one flop per word
    localparam int WORD_BITS = 32;
    localparam int WSEL_W    = $clog2(WORD_BITS);
    localparam int GRP_W     = IDX_W - WSEL_W;
    localparam int NGRP      = MAP_BYTES / WORD_BITS;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(1024);
    localparam logic [BYTE_W-1:0]   FIRST_BIT    = 8'h80;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BLK_W-1:0]  block_number;
        logic [BYTE_W-1:0] bitmap_byte;
    } req_t;

    typedef struct packed {
        logic [BLK_W-1:0] result_block;
        logic             ok;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_A_GROUP,
        OP_A_BYTE,
        OP_A_CLAIM,
        OP_R_READ,
        OP_R_SET,
        OP_L_READ,
        OP_L_WRITE,
        OP_FAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } bba_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              clear_last;
        logic              grp_any;
        logic              alloc_in_range;
        logic              rel_in_range;
        logic              rel_bit_set;
    } bba_status_t;

endpackage

// ----- rtl/block_bitmap_allocator.sv -----
// Top level of the first-fit block bitmap allocator.
// Depends on bba_pkg; instantiates bba_ctrl and bba_datapath.
//
// After reset the block holds busy high while it clears the bitmap (no block free);
// cfg writes are taken during that time. A beat is accepted when start is high and
// busy is low; its result appears on rsp, marked by done, which is high for exactly
// one cycle, and the receiver cannot stall it. rsp holds the result until the next one.
// An allocate reads in series a summary word (one bit per nonempty bitmap byte),
// then the bitmap byte, each with a registered read. A new beat may be accepted in
// the cycle that done is shown.
module block_bitmap_allocator
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  req_t                req,
    output logic                done,
    output rsp_t                rsp,
    input  logic                cfg_we,
    input  logic [ACTIVE_W-1:0] cfg_data
);

    bba_cmd_t    cmd;
    bba_status_t status;

    bba_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    bba_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

// ----- rtl/bba_datapath.sv -----
// Datapath: bitmap memory, nonempty-byte summary, size register and result register.
// Depends on bba_pkg; driven by bba_ctrl through bba_cmd_t / bba_status_t.
module bba_datapath
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  bba_cmd_t            cmd,
    output bba_status_t         status,
    input  req_t                req,
    input  logic                cfg_we,
    input  logic [ACTIVE_W-1:0] cfg_data,
    output logic                done,
    output rsp_t                rsp
);

    logic [BYTE_W-1:0]    map_mem [MAP_BYTES];
    logic [WORD_BITS-1:0] nz_mem  [NGRP];

    req_t                req_reg;
    logic [ACTIVE_W-1:0] active_bytes_reg;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic [NGRP-1:0]     grp_vec_reg, grp_vec_next;
    logic [GRP_W-1:0]    grp_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [BYTE_W-1:0]   map_q_reg;
    logic [WORD_BITS-1:0] nz_q_reg;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;

    logic [ACTIVE_W-1:0] eff_size;
    logic [IDX_W-1:0]    req_idx;
    logic [BIT_W-1:0]    req_bit;
    logic [BYTE_W-1:0]   req_mask;
    logic [GRP_W-1:0]    first_grp;
    logic [WSEL_W-1:0]   first_sel;
    logic [BIT_W-1:0]    first_bit;
    logic [IDX_W-1:0]    alloc_idx;
    logic [BYTE_W-1:0]   claim_byte;

    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr, mem_raddr;
    logic [BYTE_W-1:0]    mem_wdata;
    logic                 nz_we, nz_re;
    logic [GRP_W-1:0]     nz_waddr, nz_raddr;
    logic [WORD_BITS-1:0] nz_wdata;
    logic [WSEL_W-1:0]    upd_sel;
    logic                 upd_val;
    logic [WORD_BITS-1:0] upd_onehot, nz_new;

    assign eff_size = (active_bytes_reg > ACTIVE_W'(MAP_BYTES)) ? ACTIVE_W'(MAP_BYTES)
                                                                : active_bytes_reg;
    assign req_idx  = req_reg.block_number[BLK_W-1:BIT_W];
    assign req_bit  = req_reg.block_number[BIT_W-1:0];
    assign req_mask = FIRST_BIT >> req_bit;

    // lowest group with a nonempty byte
    always_comb
    begin
        first_grp = '0;
        for (int i = NGRP - 1; i >= 0; i--)
        begin
            if (grp_vec_reg[i])
            begin
                first_grp = GRP_W'(i);
            end
        end
    end

    // lowest nonempty byte within the summary word
    always_comb
    begin
        first_sel = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (nz_q_reg[i])
            begin
                first_sel = WSEL_W'(i);
            end
        end
    end

    // msb is the lowest block
    always_comb
    begin
        first_bit = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (map_q_reg[i])
            begin
                first_bit = BIT_W'(BYTE_W - 1 - i);
            end
        end
    end

    assign alloc_idx  = {grp_reg, first_sel};
    assign claim_byte = map_q_reg & ~(FIRST_BIT >> first_bit);

    always_comb
    begin
        status.func           = req_reg.func;
        status.clear_last     = (clr_cnt_reg == IDX_W'(MAP_BYTES - 1));
        status.grp_any        = |grp_vec_reg;
        status.alloc_in_range = ACTIVE_W'(alloc_idx) < eff_size;
        status.rel_in_range   = ACTIVE_W'(req_idx) < eff_size;
        status.rel_bit_set    = |(map_q_reg & req_mask);
    end

    // summary word update: set or clear one byte's nonempty bit
    always_comb
    begin
        upd_sel = req_idx[WSEL_W-1:0];
        upd_val = 1'b1;
        case (cmd.op)
            OP_A_CLAIM:
            begin
                upd_sel = idx_reg[WSEL_W-1:0];
                upd_val = 1'b0;
            end
            OP_L_WRITE:
            begin
                upd_val = |req_reg.bitmap_byte;
            end
            default:
            begin
                upd_val = 1'b1;
            end
        endcase
        upd_onehot = WORD_BITS'(1) << upd_sel;
        nz_new     = upd_val ? (nz_q_reg | upd_onehot) : (nz_q_reg & ~upd_onehot);
    end

    always_comb
    begin
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = req_idx;
        mem_raddr    = req_idx;
        mem_wdata    = '0;
        nz_we        = 1'b0;
        nz_re        = 1'b0;
        nz_waddr     = req_idx[IDX_W-1:WSEL_W];
        nz_raddr     = req_idx[IDX_W-1:WSEL_W];
        nz_wdata     = nz_new;
        grp_vec_next = grp_vec_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                nz_we     = 1'b1;
                nz_waddr  = clr_cnt_reg[GRP_W-1:0];
                nz_wdata  = '0;
            end
            OP_A_GROUP:
            begin
                nz_re    = 1'b1;
                nz_raddr = first_grp;
            end
            OP_A_BYTE:
            begin
                mem_re    = 1'b1;
                mem_raddr = alloc_idx;
            end
            OP_A_CLAIM:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = claim_byte;
                if (claim_byte == '0)
                begin
                    nz_we    = 1'b1;
                    nz_waddr = idx_reg[IDX_W-1:WSEL_W];
                    grp_vec_next[idx_reg[IDX_W-1:WSEL_W]] = |nz_new;
                end
                done_next             = 1'b1;
                rsp_next.result_block = {idx_reg, first_bit};
                rsp_next.ok           = 1'b1;
            end
            OP_R_READ:
            begin
                mem_re = 1'b1;
                nz_re  = 1'b1;
            end
            OP_R_SET:
            begin
                mem_we    = 1'b1;
                mem_wdata = map_q_reg | req_mask;
                nz_we     = 1'b1;
                grp_vec_next[req_idx[IDX_W-1:WSEL_W]] = 1'b1;
                done_next             = 1'b1;
                rsp_next.result_block = '0;
                rsp_next.ok           = 1'b1;
            end
            OP_L_READ:
            begin
                nz_re = 1'b1;
            end
            OP_L_WRITE:
            begin
                // a 13-bit block number always gives a byte index inside the map
                mem_we    = 1'b1;
                mem_wdata = req_reg.bitmap_byte;
                nz_we     = 1'b1;
                grp_vec_next[req_idx[IDX_W-1:WSEL_W]] = |nz_new;
                done_next             = 1'b1;
                rsp_next.result_block = '0;
                rsp_next.ok           = 1'b1;
            end
            OP_FAIL:
            begin
                done_next             = 1'b1;
                rsp_next.result_block = '0;
                rsp_next.ok           = 1'b0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bytes_reg <= ACTIVE_RESET;
            clr_cnt_reg      <= '0;
            grp_vec_reg      <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                active_bytes_reg <= cfg_data;
            end
            if (cmd.op == OP_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            grp_vec_reg <= grp_vec_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            req_reg <= req;
        end
        if (cmd.op == OP_A_GROUP)
        begin
            grp_reg <= first_grp;
        end
        if (cmd.op == OP_A_BYTE)
        begin
            idx_reg <= alloc_idx;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            map_q_reg <= map_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nz_we)
        begin
            nz_mem[nz_waddr] <= nz_wdata;
        end
        if (nz_re)
        begin
            nz_q_reg <= nz_mem[nz_raddr];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ----- rtl/bba_ctrl.sv -----
// Controller state machine: sequences the clearing pass and each operation.
// Depends on bba_pkg; commands bba_datapath through bba_cmd_t / bba_status_t.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  bba_status_t status,
    output bba_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_A_WORD,
        S_A_CLAIM,
        S_R_CHECK,
        S_L_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (status.func)
                    FUNC_ALLOC:
                    begin
                        if (status.grp_any)
                        begin
                            cmd.op     = OP_A_GROUP;
                            state_next = S_A_WORD;
                        end
                        else
                        begin
                            cmd.op = OP_FAIL;
                        end
                    end
                    FUNC_RELEASE:
                    begin
                        if (status.rel_in_range)
                        begin
                            cmd.op     = OP_R_READ;
                            state_next = S_R_CHECK;
                        end
                        else
                        begin
                            cmd.op = OP_FAIL;
                        end
                    end
                    FUNC_LOAD:
                    begin
                        cmd.op     = OP_L_READ;
                        state_next = S_L_WRITE;
                    end
                    default:
                    begin
                        cmd.op = OP_FAIL;
                    end
                endcase
            end
            S_A_WORD:
            begin
                // first nonempty byte past the active size: nothing free in range
                if (status.alloc_in_range)
                begin
                    cmd.op     = OP_A_BYTE;
                    state_next = S_A_CLAIM;
                end
                else
                begin
                    cmd.op     = OP_FAIL;
                    state_next = S_IDLE;
                end
            end
            S_A_CLAIM:
            begin
                cmd.op     = OP_A_CLAIM;
                state_next = S_IDLE;
            end
            S_R_CHECK:
            begin
                cmd.op     = status.rel_bit_set ? OP_FAIL : OP_R_SET;
                state_next = S_IDLE;
            end
            S_L_WRITE:
            begin
                cmd.op     = OP_L_WRITE;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// ----- rtl/bba_checker.sv -----
// Port-level checker for block_bitmap_allocator, attached by bind.
// Depends on bba_pkg.
module bba_checker
    import bba_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    // a failed beat never reports a block number
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !rsp.ok |-> rsp.result_block == '0)
        else $error("failed result carries a nonzero block");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted beat did not raise busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// ----- sim/block_bitmap_allocator_test.sv -----
// Self-checking bench for block_bitmap_allocator: allocate, release and load beats
// are checked against a behavioral copy of the free-block bitmap.
// Depends on bba_pkg and the block_bitmap_allocator RTL.
module block_bitmap_allocator_test;
    import bba_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int QUIET_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;

    typedef enum logic [1:0] {
        STIM_BEAT,
        STIM_SIZE,
        STIM_DRAIN
    } stim_kind_t;

    typedef struct packed {
        stim_kind_t          kind;
        req_t                beat;
        logic [ACTIVE_W-1:0] size;
    } stim_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    req_t                req = '0;
    logic                done;
    rsp_t                rsp;
    logic                cfg_we = 1'b0;
    logic [ACTIVE_W-1:0] cfg_data = '0;

    // model state
    logic [BYTE_W-1:0]   free_bits [MAP_BYTES];
    logic [ACTIVE_W-1:0] size_reg;

    stim_t stim_q[$];
    rsp_t  reply_q[$];

    logic beat_taken = 1'b0;
    logic calm = 1'b0;
    int   idle_left = 0;
    int   quiet = 0;
    int   stall = 0;
    int   n_beats = 0;
    int   n_settings = 0;
    int   n_granted = 0;
    int   n_refused = 0;
    int   n_errors = 0;

    block_bitmap_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one beat to the bitmap copy and returns the reply it must produce.
    function automatic rsp_t next_reply(req_t r);
        rsp_t o;
        int   lim;
        int   idx;
        int   b;
        int   i;
        int   k;
        logic hit;
        o   = '0;
        hit = 1'b0;
        lim = (int'(size_reg) > MAP_BYTES) ? MAP_BYTES : int'(size_reg);
        idx = int'(r.block_number >> BIT_W);
        b   = int'(r.block_number[BIT_W-1:0]);
        case (r.func)
            FUNC_ALLOC:
            begin
                for (i = 0; i < lim && !hit; i++)
                begin
                    if (free_bits[i] != '0)
                    begin
                        // msb is the lowest block of the byte
                        for (k = 0; k < BYTE_W && !hit; k++)
                        begin
                            if (free_bits[i][BYTE_W-1-k])
                            begin
                                free_bits[i][BYTE_W-1-k] = 1'b0;
                                o.result_block = BLK_W'(i * BYTE_W + k);
                                o.ok = 1'b1;
                                hit = 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_RELEASE:
            begin
                if (idx < lim && !free_bits[idx][BYTE_W-1-b])
                begin
                    free_bits[idx][BYTE_W-1-b] = 1'b1;
                    o.ok = 1'b1;
                end
            end
            FUNC_LOAD:
            begin
                if (idx < MAP_BYTES)
                begin
                    free_bits[idx] = r.bitmap_byte;
                    o.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic void add_beat(logic [FUNC_W-1:0] f, logic [BLK_W-1:0] blk,
                                     logic [BYTE_W-1:0] val);
        stim_t s;
        s = '0;
        s.kind = STIM_BEAT;
        s.beat.func = f;
        s.beat.block_number = blk;
        s.beat.bitmap_byte = val;
        stim_q.push_back(s);
    endfunction

    function automatic void add_size(logic [ACTIVE_W-1:0] sz);
        stim_t s;
        s = '0;
        s.kind = STIM_SIZE;
        s.size = sz;
        stim_q.push_back(s);
    endfunction

    function automatic void add_drain();
        stim_t s;
        s = '0;
        s.kind = STIM_DRAIN;
        stim_q.push_back(s);
    endfunction

    // driver: one assignment per signal per falling edge
    always @(negedge clk)
    begin
        logic                nx_start;
        req_t                nx_req;
        logic                nx_we;
        logic [ACTIVE_W-1:0] nx_data;
        int                  r;
        nx_start = start;
        nx_req   = req;
        nx_we    = 1'b0;
        nx_data  = cfg_data;
        if (rst_n)
        begin
            if (!start && reply_q.size() == 0)
                quiet++;
            else
                quiet = 0;
            if (start && beat_taken)
            begin
                nx_start = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    calm = !calm;
                r = $urandom_range(0, 99);
                if (calm || r < 55)
                    idle_left = 0;
                else if (r < 88)
                    idle_left = $urandom_range(1, 3);
                else if (r < 97)
                    idle_left = $urandom_range(4, 12);
                else
                    idle_left = $urandom_range(20, 60);
            end
            if (!nx_start)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (stim_q.size() > 0)
                begin
                    case (stim_q[0].kind)
                        STIM_BEAT:
                        begin
                            nx_start = 1'b1;
                            nx_req = stim_q[0].beat;
                            stim_q.delete(0);
                        end
                        STIM_SIZE:
                        begin
                            // only with the block idle for a while
                            if (quiet >= QUIET_CYCLES)
                            begin
                                nx_we = 1'b1;
                                nx_data = stim_q[0].size;
                                stim_q.delete(0);
                            end
                        end
                        default:
                        begin
                            if (reply_q.size() == 0)
                                stim_q.delete(0);
                        end
                    endcase
                end
            end
        end
        start    <= nx_start;
        req      <= nx_req;
        cfg_we   <= nx_we;
        cfg_data <= nx_data;
    end

    // monitor, predictor update and watchdog
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (reply_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result, expected none, got block %0d ok %0b",
                             $time, rsp.result_block, rsp.ok);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (rsp.result_block !== want.result_block)
                    begin
                        n_errors++;
                        $display("%0t: result_block expected %0d got %0d",
                                 $time, want.result_block, rsp.result_block);
                    end
                    if (rsp.ok !== want.ok)
                    begin
                        n_errors++;
                        $display("%0t: ok expected %0b got %0b", $time, want.ok, rsp.ok);
                    end
                    if (want.ok)
                        n_granted++;
                    else
                        n_refused++;
                end
            end
            if (cfg_we)
            begin
                size_reg = cfg_data;
                n_settings++;
            end
            beat_taken = start && !busy;
            if (beat_taken)
            begin
                reply_q.push_back(next_reply(req));
                n_beats++;
            end
            if (done || cfg_we || beat_taken)
                stall = 0;
            else
                stall++;
            if (stall >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, stall);
                $display("block_bitmap_allocator_test NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int                  i;
        int                  ph;
        int                  n;
        int                  span;
        int                  low;
        int                  pick;
        int                  idx;
        logic [ACTIVE_W-1:0] sz;
        logic [BYTE_W-1:0]   val;

        for (i = 0; i < MAP_BYTES; i++)
            free_bits[i] = '0;
        size_reg = ACTIVE_RESET;

        // directed: full size after reset, map empty
        add_beat(FUNC_ALLOC, 13'd0, 8'h00);         // nothing free
        add_beat(FUNC_RELEASE, 13'd8191, 8'hFF);    // last block of the map
        add_beat(FUNC_RELEASE, 13'd8191, 8'h00);    // double release
        add_beat(FUNC_LOAD, 13'd7, 8'h80);
        add_beat(FUNC_ALLOC, 13'd8191, 8'hFF);      // block 0, told apart by ok
        add_beat(FUNC_ALLOC, 13'd0, 8'h00);
        add_beat(FUNC_ALLOC, 13'd0, 8'h00);
        add_beat(FUNC_LOAD, 13'd8191, 8'hFF);
        add_beat(FUNC_LOAD, 13'd2, 8'h01);
        add_beat(FUNC_ALLOC, 13'd0, 8'h00);
        add_beat(FUNC_ALLOC, 13'd0, 8'h00);
        add_beat(FUNC_SPARE, 13'd8191, 8'hFF);
        add_beat(FUNC_SPARE, 13'd0, 8'h00);
        add_beat(FUNC_RELEASE, 13'd0, 8'h00);
        add_beat(FUNC_RELEASE, 13'd0, 8'h00);
        add_drain();
        add_size(11'd1);
        add_beat(FUNC_RELEASE, 13'd8, 8'h00);       // beyond active size
        add_beat(FUNC_LOAD, 13'd40, 8'hFF);         // outside active size, still written
        add_beat(FUNC_ALLOC, 13'd0, 8'h00);
        add_beat(FUNC_ALLOC, 13'd0, 8'h00);
        add_size(11'd0);                            // no byte active
        add_beat(FUNC_ALLOC, 13'd0, 8'h00);
        add_beat(FUNC_RELEASE, 13'd0, 8'h00);
        add_size(11'd2047);                         // clamps to the map size
        add_beat(FUNC_ALLOC, 13'd0, 8'h00);
        add_beat(FUNC_RELEASE, 13'd8191, 8'h00);

        // random phases, one size setting each
        for (ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: sz = 11'd1;
                1: sz = 11'd2;
                2: sz = 11'd1024;
                3: sz = 11'd0;
                4: sz = 11'd2047;
                5: sz = 11'd1025;
                6: sz = 11'd8;
                7: sz = ACTIVE_W'($urandom_range(3, 24));
                8: sz = ACTIVE_W'($urandom_range(0, 2047));
                default: sz = ACTIVE_W'($urandom_range(1, 6));
            endcase
            add_size(sz);
            span = (int'(sz) > MAP_BYTES) ? MAP_BYTES : int'(sz);
            if (span == 0)
                span = 4;
            low = (span < 8) ? span : 8;
            // seed the lowest bytes so allocations can succeed
            for (i = 0; i < low; i++)
                add_beat(FUNC_LOAD, BLK_W'(i * BYTE_W + $urandom_range(0, 7)),
                         ($urandom_range(0, 2) == 0) ? 8'hFF : BYTE_W'($urandom_range(1, 255)));
            for (n = 0; n < 148; n++)
            begin
                if (n == 74)
                    add_drain();
                pick = $urandom_range(0, 99);
                idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, low - 1)
                                                  : $urandom_range(0, span - 1);
                if (pick < 45)
                    add_beat(FUNC_ALLOC, BLK_W'($urandom_range(0, 8191)),
                             BYTE_W'($urandom_range(0, 255)));
                else if (pick < 70)
                    add_beat(FUNC_RELEASE, BLK_W'(idx * BYTE_W + $urandom_range(0, 7)),
                             BYTE_W'($urandom_range(0, 255)));
                else if (pick < 88)
                begin
                    case ($urandom_range(0, 3))
                        0: val = 8'hFF;
                        1: val = 8'h00;
                        2: val = FIRST_BIT >> $urandom_range(0, 7);
                        default: val = BYTE_W'($urandom_range(0, 255));
                    endcase
                    add_beat(FUNC_LOAD, BLK_W'(idx * BYTE_W + $urandom_range(0, 7)), val);
                end
                else
                    add_beat(FUNC_W'($urandom_range(0, 3)), BLK_W'($urandom_range(0, 8191)),
                             BYTE_W'($urandom_range(0, 255)));
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() != 0 || start || reply_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (reply_q.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d expected results never arrived", $time, reply_q.size());
        end
        $display("covered %0d beats under %0d size settings (incl. zero and clamped sizes)",
                 n_beats, n_settings);
        $display("replies: %0d granted, %0d refused, %0d errors", n_granted, n_refused, n_errors);
        if (n_errors == 0)
            $display("block_bitmap_allocator_test OK");
        else
            $display("block_bitmap_allocator_test NOT OK");
        $finish;
    end

endmodule
